@@ rtl/snm_pkg.sv @@
`default_nettype none
package snm_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOTAL_W     = ADDR_W + 1;
    localparam int DIM_W       = 10;
    localparam int COORD_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_W    = 16;
    localparam int SLOPE_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int TAPS        = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE       = 2'd2;

    localparam logic [1:0] POS_LEFT   = 2'd0;
    localparam logic [1:0] POS_MID    = 2'd1;
    localparam logic [1:0] POS_RIGHT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVXY,
        ST_ADDR,
        ST_READ,
        ST_SCALE,
        ST_SQUARE,
        ST_SUM,
        ST_ISQRT,
        ST_DIVSET,
        ST_DIVSTEP,
        ST_FINISH
    } state_t;

    // Neighbor order: row above (left, mid, right), own row (left, right),
    // row below (left, mid, right).
    function automatic logic [1:0] tap_col(input logic [2:0] k);
        case (k)
            3'd0, 3'd3, 3'd5: tap_col = POS_LEFT;
            3'd1, 3'd6:       tap_col = POS_MID;
            default:          tap_col = POS_RIGHT;
        endcase
    endfunction

    function automatic logic [1:0] tap_row(input logic [2:0] k);
        case (k)
            3'd0, 3'd1, 3'd2: tap_row = POS_LEFT;
            3'd3, 3'd4:       tap_row = POS_MID;
            default:          tap_row = POS_RIGHT;
        endcase
    endfunction

    function automatic logic signed [2:0] tap_wx(input logic [2:0] k);
        case (k)
            3'd0, 3'd5: tap_wx = -3'sd1;
            3'd2, 3'd7: tap_wx = 3'sd1;
            3'd3:       tap_wx = -3'sd2;
            3'd4:       tap_wx = 3'sd2;
            default:    tap_wx = 3'sd0;
        endcase
    endfunction

    function automatic logic signed [2:0] tap_wy(input logic [2:0] k);
        case (k)
            3'd0, 3'd2: tap_wy = 3'sd1;
            3'd1:       tap_wy = 3'sd2;
            3'd5, 3'd7: tap_wy = -3'sd1;
            3'd6:       tap_wy = -3'sd2;
            default:    tap_wy = 3'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ rtl/snm_ram.sv @@
`default_nettype none
module snm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ rtl/wrapped_sobel_normal_map_unit.sv @@
`default_nettype none
// Sobel normal map unit with toroidal wrap.
// Input channel s_*: s_tuser selects the request kind (0 load a height
// sample, 1 emit the next normal); s_tdata carries the height (0.16).
// Loads fill the height tile in raster order, one request per cycle
// while the unit is idle, and produce no result. Once the tile is full
// each emit returns one normal on m_*: m_tdata = red, green, blue bytes,
// m_tlast marks the tile's final pixel, m_tuser flags an emit that came
// before the tile was loaded (then all bytes are zero).
// Configuration: cfg_wr_en / cfg_addr / cfg_wr_data write tile_width,
// tile_height and slope_q8; write only while the unit is idle.
// Steps of a loaded emit: the pixel's column and row divide, the eight
// neighbor reads from the single-port height RAM, the bit-serial square
// root and three restoring divisions to bytes, plus the address, scale,
// square, sum, divide-setup and finish steps. An early emit goes straight
// to the finish step; a load is taken in the idle state and needs none.
// Reset (aresetn low, synchronous) empties the tile and restores the
// register defaults; the RAM contents are not cleared.
// When m_tready is low the result holds in the output register; loads
// are still taken, and an emit waits in its last step until the
// register frees.
module wrapped_sobel_normal_map_unit
    import snm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // [15:0] height_value
    input  wire logic                 s_tuser,   // [0] action
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [23:0]          m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic                      m_tlast,   // last_pixel
    output logic                      m_tuser,   // [0] not_loaded
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [15:0]          cfg_wr_data
);

    // control
    state_t               state_reg, state_next;
    logic [DIM_W-1:0]     width_cfg_reg, width_cfg_next;
    logic [DIM_W-1:0]     height_cfg_reg, height_cfg_next;
    logic [SLOPE_W-1:0]   slope_reg, slope_next;
    logic [ADDR_W-1:0]    load_pos_reg, load_pos_next;
    logic [ADDR_W-1:0]    emit_pos_reg, emit_pos_next;
    logic                 ready_reg, ready_next;
    logic                 m_valid_reg, m_valid_next;
    logic [4:0]           step_reg, step_next;
    logic [1:0]           comp_reg, comp_next;

    // payload
    logic [ADDR_W-1:0]    p_reg, p_next;
    logic [ADDR_W-1:0]    rem_reg, rem_next;
    logic [ADDR_W:0]      wsh_reg, wsh_next;
    logic [ROW_W-1:0]     yq_reg, yq_next;
    logic [COORD_W-1:0]   xl_reg, xl_next, xr_reg, xr_next;
    logic [ADDR_W-1:0]    base_u_reg, base_u_next;
    logic [ADDR_W-1:0]    base_c_reg, base_c_next;
    logic [ADDR_W-1:0]    base_d_reg, base_d_next;
    logic                 last_reg, last_next;
    logic                 nl_reg, nl_next;
    logic                 emit_ok_reg, emit_ok_next;
    logic signed [19:0]   gx_reg, gx_next, gy_reg, gy_next;
    logic [29:0]          nx_mag_reg, nx_mag_next, ny_mag_reg, ny_mag_next;
    logic                 nx_neg_reg, nx_neg_next, ny_neg_reg, ny_neg_next;
    logic [59:0]          sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [61:0]          sv_reg, sv_next;
    logic [62:0]          sres_reg, sres_next;
    logic [62:0]          sbit_reg, sbit_next;
    logic [40:0]          drem_reg, drem_next;
    logic [40:0]          dsh_reg, dsh_next;
    logic [7:0]           dq_reg, dq_next;
    logic [7:0]           red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [23:0]          m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_nl_reg, m_nl_next;

    // RAM port
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [HEIGHT_W-1:0]  ram_rdata;

    // clamped dimensions
    logic [DIM_W-1:0]     w_dim, h_dim;
    logic [TOTAL_W-1:0]   total;
    logic                 s_acc;
    logic                 out_free;

    always_comb begin
        if (width_cfg_reg < DIM_W'(4))              w_dim = DIM_W'(4);
        else if (width_cfg_reg > DIM_W'(MAX_WIDTH)) w_dim = DIM_W'(MAX_WIDTH);
        else                                        w_dim = width_cfg_reg;
        if (height_cfg_reg < DIM_W'(4))               h_dim = DIM_W'(4);
        else if (height_cfg_reg > DIM_W'(MAX_HEIGHT)) h_dim = DIM_W'(MAX_HEIGHT);
        else                                          h_dim = height_cfg_reg;
    end

    assign total    = TOTAL_W'(w_dim) * TOTAL_W'(h_dim);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_nl_reg;

    snm_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (STORE_DEPTH)
    ) u_height_ram (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata),
        .rdata (ram_rdata)
    );

    assign ram_addr = ram_we ? load_pos_reg : rd_addr;

    // neighbor address for the current read step
    logic [2:0]           tap_k, tap_prev;
    logic [ADDR_W-1:0]    row_base;
    logic [COORD_W-1:0]   col_val;

    always_comb begin
        tap_k    = step_reg[2:0];
        tap_prev = 3'(step_reg - 5'd1);
        case (tap_row(tap_k))
            POS_LEFT: row_base = base_u_reg;
            POS_MID:  row_base = base_c_reg;
            default:  row_base = base_d_reg;
        endcase
        case (tap_col(tap_k))
            POS_LEFT: col_val = xl_reg;
            POS_MID:  col_val = rem_reg[COORD_W-1:0];
            default:  col_val = xr_reg;
        endcase
        rd_addr = row_base + ADDR_W'(col_val);
    end

    // datapath temporaries
    logic [TOTAL_W-1:0]   load_inc;
    logic [COORD_W-1:0]   x_cur;
    logic [ADDR_W:0]      rem_ext;
    logic signed [19:0]   samp_s;
    logic [17:0]          gx_abs, gy_abs;
    logic [33:0]          prod_x, prod_y;
    logic [62:0]          trial;
    logic signed [32:0]   comp_c;
    logic [32:0]          c_plus_len;
    logic [30:0]          len_val;

    always_comb begin
        state_next      = state_reg;
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        slope_next      = slope_reg;
        load_pos_next   = load_pos_reg;
        emit_pos_next   = emit_pos_reg;
        ready_next      = ready_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        step_next       = step_reg;
        comp_next       = comp_reg;
        p_next          = p_reg;
        rem_next        = rem_reg;
        wsh_next        = wsh_reg;
        yq_next         = yq_reg;
        xl_next         = xl_reg;
        xr_next         = xr_reg;
        base_u_next     = base_u_reg;
        base_c_next     = base_c_reg;
        base_d_next     = base_d_reg;
        last_next       = last_reg;
        nl_next         = nl_reg;
        emit_ok_next    = emit_ok_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        nx_mag_next     = nx_mag_reg;
        ny_mag_next     = ny_mag_reg;
        nx_neg_next     = nx_neg_reg;
        ny_neg_next     = ny_neg_reg;
        sqx_next        = sqx_reg;
        sqy_next        = sqy_reg;
        sv_next         = sv_reg;
        sres_next       = sres_reg;
        sbit_next       = sbit_reg;
        drem_next       = drem_reg;
        dsh_next        = dsh_reg;
        dq_next         = dq_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_nl_next       = m_nl_reg;
        ram_we          = 1'b0;

        load_inc   = TOTAL_W'(load_pos_reg) + TOTAL_W'(1);
        x_cur      = rem_reg[COORD_W-1:0];
        rem_ext    = {1'b0, rem_reg};
        samp_s     = signed'(20'(ram_rdata));
        gx_abs     = gx_reg[19] ? 18'(-gx_reg) : 18'(gx_reg);
        gy_abs     = gy_reg[19] ? 18'(-gy_reg) : 18'(gy_reg);
        prod_x     = 34'(gx_abs) * 34'(slope_reg);
        prod_y     = 34'(gy_abs) * 34'(slope_reg);
        trial      = sres_reg + sbit_reg;
        len_val    = sres_reg[30:0];
        case (comp_reg)
            2'd0:    comp_c = nx_neg_reg ? -33'(nx_mag_reg) : 33'(nx_mag_reg);
            2'd1:    comp_c = ny_neg_reg ? -33'(ny_mag_reg) : 33'(ny_mag_reg);
            default: comp_c = 33'sd1048576;
        endcase
        c_plus_len = 33'(comp_c + signed'(33'(len_val)));

        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TILE_WIDTH:  width_cfg_next  = cfg_wr_data[DIM_W-1:0];
                CFG_TILE_HEIGHT: height_cfg_next = cfg_wr_data[DIM_W-1:0];
                CFG_SLOPE:       slope_next      = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (!s_tuser) begin
                        // load: store while the tile is short, then mark it ready
                        if (!ready_reg) begin
                            if (TOTAL_W'(load_pos_reg) < total) begin
                                ram_we        = 1'b1;
                                load_pos_next = load_inc[ADDR_W-1:0];
                                ready_next    = (load_inc >= total);
                            end else begin
                                ready_next    = 1'b1;
                            end
                        end
                    end else if (!ready_reg) begin
                        red_next     = 8'd0;
                        green_next   = 8'd0;
                        blue_next    = 8'd0;
                        last_next    = 1'b0;
                        nl_next      = 1'b1;
                        emit_ok_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else begin
                        if (TOTAL_W'(emit_pos_reg) < total) begin
                            p_next   = emit_pos_reg;
                            rem_next = emit_pos_reg;
                        end else begin
                            p_next   = ADDR_W'(total - TOTAL_W'(1));
                            rem_next = ADDR_W'(total - TOTAL_W'(1));
                        end
                        wsh_next   = (ADDR_W + 1)'(w_dim) << (ROW_W - 1);
                        yq_next    = '0;
                        step_next  = '0;
                        state_next = ST_DIVXY;
                    end
                end
            end
            ST_DIVXY: begin
                // one quotient bit of row = p / width per cycle
                if (rem_ext >= wsh_reg) begin
                    rem_next = ADDR_W'(rem_ext - wsh_reg);
                    yq_next  = {yq_reg[ROW_W-2:0], 1'b1};
                end else begin
                    yq_next  = {yq_reg[ROW_W-2:0], 1'b0};
                end
                wsh_next  = wsh_reg >> 1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(ROW_W - 1)) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                xl_next = (x_cur == '0) ? COORD_W'(w_dim - DIM_W'(1)) : x_cur - COORD_W'(1);
                xr_next = (DIM_W'(x_cur) == w_dim - DIM_W'(1)) ? '0 : x_cur + COORD_W'(1);
                base_c_next = p_reg - ADDR_W'(x_cur);
                base_u_next = (yq_reg == '0) ? ADDR_W'(total - TOTAL_W'(w_dim))
                                             : p_reg - ADDR_W'(x_cur) - ADDR_W'(w_dim);
                base_d_next = (DIM_W'(yq_reg) == h_dim - DIM_W'(1)) ? '0
                                             : p_reg - ADDR_W'(x_cur) + ADDR_W'(w_dim);
                last_next    = (TOTAL_W'(p_reg) + TOTAL_W'(1) >= total);
                nl_next      = 1'b0;
                emit_ok_next = 1'b1;
                gx_next      = '0;
                gy_next      = '0;
                step_next    = '0;
                state_next   = ST_READ;
            end
            ST_READ: begin
                // issue one neighbor read per cycle, accumulate the previous one
                if (step_reg != 5'd0) begin
                    gx_next = gx_reg + samp_s * 20'(tap_wx(tap_prev));
                    gy_next = gy_reg + samp_s * 20'(tap_wy(tap_prev));
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(TAPS)) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                nx_mag_next = 30'((prod_x + 34'd8) >> 4);
                ny_mag_next = 30'((prod_y + 34'd8) >> 4);
                nx_neg_next = !gx_reg[19] && (gx_reg != '0);
                ny_neg_next = !gy_reg[19] && (gy_reg != '0);
                state_next  = ST_SQUARE;
            end
            ST_SQUARE: begin
                sqx_next   = 60'(nx_mag_reg) * 60'(nx_mag_reg);
                sqy_next   = 60'(ny_mag_reg) * 60'(ny_mag_reg);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sv_next    = 62'(sqx_reg) + 62'(sqy_reg) + (62'd1 << 40);
                sres_next  = '0;
                sbit_next  = 63'd1 << 62;
                step_next  = '0;
                state_next = ST_ISQRT;
            end
            ST_ISQRT: begin
                if ({1'b0, sv_reg} >= trial) begin
                    sv_next   = 62'({1'b0, sv_reg} - trial);
                    sres_next = (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_next = sres_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    comp_next  = 2'd0;
                    state_next = ST_DIVSET;
                end
            end
            ST_DIVSET: begin
                // byte = (510 * (c + len) + 2 * len) / (4 * len), quotient below 256
                drem_next  = 41'(c_plus_len) * 41'd510 + (41'(len_val) << 1);
                dsh_next   = 41'(len_val) << 9;
                dq_next    = '0;
                step_next  = '0;
                state_next = ST_DIVSTEP;
            end
            ST_DIVSTEP: begin
                if (drem_reg >= dsh_reg) begin
                    drem_next = drem_reg - dsh_reg;
                    dq_next   = {dq_reg[6:0], 1'b1};
                end else begin
                    dq_next   = {dq_reg[6:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd7) begin
                    case (comp_reg)
                        2'd0:    red_next   = dq_next;
                        2'd1:    green_next = dq_next;
                        default: blue_next  = dq_next;
                    endcase
                    if (comp_reg == 2'd2) begin
                        state_next = ST_FINISH;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_DIVSET;
                    end
                end
            end
            ST_FINISH: begin
                // hold until the output register frees, then advance the tile after a loaded emit
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {blue_reg, green_reg, red_reg};
                    m_last_next  = last_reg;
                    m_nl_next    = nl_reg;
                    if (emit_ok_reg) begin
                        if (last_reg) begin
                            load_pos_next = '0;
                            emit_pos_next = '0;
                            ready_next    = 1'b0;
                        end else begin
                            emit_pos_next = p_reg + ADDR_W'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            width_cfg_reg  <= DIM_W'(512);
            height_cfg_reg <= DIM_W'(512);
            slope_reg      <= SLOPE_W'(384);
            load_pos_reg   <= '0;
            emit_pos_reg   <= '0;
            ready_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            step_reg       <= '0;
            comp_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            slope_reg      <= slope_next;
            load_pos_reg   <= load_pos_next;
            emit_pos_reg   <= emit_pos_next;
            ready_reg      <= ready_next;
            m_valid_reg    <= m_valid_next;
            step_reg       <= step_next;
            comp_reg       <= comp_next;
        end
        p_reg       <= p_next;
        rem_reg     <= rem_next;
        wsh_reg     <= wsh_next;
        yq_reg      <= yq_next;
        xl_reg      <= xl_next;
        xr_reg      <= xr_next;
        base_u_reg  <= base_u_next;
        base_c_reg  <= base_c_next;
        base_d_reg  <= base_d_next;
        last_reg    <= last_next;
        nl_reg      <= nl_next;
        emit_ok_reg <= emit_ok_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        nx_mag_reg  <= nx_mag_next;
        ny_mag_reg  <= ny_mag_next;
        nx_neg_reg  <= nx_neg_next;
        ny_neg_reg  <= ny_neg_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        sv_reg      <= sv_next;
        sres_reg    <= sres_next;
        sbit_reg    <= sbit_next;
        drem_reg    <= drem_next;
        dsh_reg     <= dsh_next;
        dq_reg      <= dq_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_nl_reg    <= m_nl_next;
    end

endmodule
`default_nettype wire

@@ rtl/snm_checker.sv @@
`default_nettype none
module snm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // early emit carries zero bytes and no tile end
    a_not_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 24'd0 && !m_tlast)
        else $error("not-loaded result has data");

    // z is positive, so blue maps to the upper half
    a_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[23])
        else $error("blue byte below midscale");

    // reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind wrapped_sobel_normal_map_unit snm_checker u_snm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
